// ===== src/fgrb_pkg.sv =====
// shared types, constants and codes of the framed gradient rectangle blender
package fgrb_pkg;

  // largest rectangle side in pixels
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM);
  // width of a dimension register
  localparam int CFG_W   = 13;
  // compare width wide enough for a counter plus a dimension register
  localparam int CMP_W   = ((CFG_W > DIM_W) ? CFG_W : DIM_W) + 2;
  // gradient_step times position
  localparam int PROD_W  = 8 + DIM_W;
  // gradient divisor, at most 8191 / 255 = 32
  localparam int DIVR_W  = 6;
  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [2:0] REG_FRAME_PIXEL   = 3'd0;
  localparam logic [2:0] REG_FILL_PIXEL    = 3'd1;
  localparam logic [2:0] REG_FILL_STYLE    = 3'd2;
  localparam logic [2:0] REG_GRADIENT_STEP = 3'd3;
  localparam logic [2:0] REG_RECT_WIDTH    = 3'd4;
  localparam logic [2:0] REG_RECT_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd6;
  localparam logic [2:0] REG_GRADIENT_SPAN = 3'd7;

  // fill styles
  localparam logic [2:0] STYLE_FLAT   = 3'd0;
  localparam logic [2:0] STYLE_VERT   = 3'd1;
  localparam logic [2:0] STYLE_VREV   = 3'd2;
  localparam logic [2:0] STYLE_HORZ   = 3'd3;
  localparam logic [2:0] STYLE_HREV   = 3'd4;

  // full opacity in percent and channel maximum
  localparam logic [7:0] PCT_FULL = 8'd100;
  localparam logic [7:0] PIX_MAX  = 8'd255;

  typedef struct packed {
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
    logic       setting_error;
  } pix_out_t;

  typedef struct packed {
    logic [31:0]      frame_pixel;
    logic [31:0]      fill_pixel;
    logic [2:0]       fill_style;
    logic [7:0]       gradient_step;
    logic [CFG_W-1:0] rect_width;
    logic [CFG_W-1:0] rect_height;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] gradient_span;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    pix_in_t          bg;
    logic             frame;
    logic             last;
    logic [DIM_W-1:0] pos;
  } work_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_resp_t;

endpackage

// ===== src/fgrb_front.sv =====
// front end: pixel acceptance, row and column counters, frame classification
module fgrb_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fgrb_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fgrb_pkg::pix_in_t in_data_i,
  input  logic             full_i,
  output logic             push_o,
  output fgrb_pkg::work_t  work_o
);
  import fgrb_pkg::*;

  logic [DIM_W-1:0] row_q, row_d, col_q, col_d;
  logic [CMP_W-1:0] w, h, fw, row_e, col_e;
  logic             frame, last, col_wrap;
  logic [DIM_W-1:0] pos;

  // zero reads as one, oversize reads as the maximum
  function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) begin
      return CMP_W'(1);
    end else if (ve > CMP_W'(MAX_DIM)) begin
      return CMP_W'(MAX_DIM);
    end
    return ve;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // classification of the current position
  always_comb begin
    w     = clamp_dim(cfg_i.rect_width);
    h     = clamp_dim(cfg_i.rect_height);
    fw    = CMP_W'(cfg_i.frame_width);
    row_e = CMP_W'(row_q);
    col_e = CMP_W'(col_q);
    frame = (row_e < fw) || (row_e + fw >= h) || (col_e < fw) || (col_e + fw >= w);
    unique case (cfg_i.fill_style)
      STYLE_VERT: pos = row_q;
      STYLE_VREV: pos = (h > row_e) ? DIM_W'(h - row_e - CMP_W'(1)) : '0;
      STYLE_HORZ: pos = col_q;
      STYLE_HREV: pos = (w > col_e) ? DIM_W'(w - col_e - CMP_W'(1)) : '0;
      default:    pos = '0;
    endcase
    col_wrap = (col_e + CMP_W'(1) >= w);
    last     = col_wrap && (row_e + CMP_W'(1) >= h);
  end

  // raster advance on each transfer
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign work_o.bg    = in_data_i;
  assign work_o.frame = frame;
  assign work_o.last  = last;
  assign work_o.pos   = pos;

endmodule

// ===== src/fgrb_queue.sv =====
// short queue of classified pixels between front and back
module fgrb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fgrb_pkg::work_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output fgrb_pkg::work_t data_o,
  output logic            empty_o
);
  import fgrb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  work_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue pop while empty");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a transfer");

endmodule

// ===== src/fgrb_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module fgrb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fgrb_pkg::div_req_t  req_i,
  output fgrb_pkg::div_resp_t resp_o
);
  import fgrb_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] quo_q;
  logic [DIVR_W-1:0] rem_q, dsr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIVR_W:0]   trial;
  logic              qbit;
  logic [DIVR_W-1:0] rem_next;

  // one shift and subtract step
  always_comb begin
    trial    = {rem_q, quo_q[PROD_W-1]};
    qbit     = (trial >= {1'b0, dsr_q});
    rem_next = qbit ? DIVR_W'(trial - {1'b0, dsr_q}) : DIVR_W'(trial);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_W-2:0], qbit};
      rem_q <= rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PROD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign resp_o.busy     = busy_q;
  assign resp_o.done     = done_q;
  assign resp_o.quotient = quo_q;

endmodule

// ===== src/fgrb_back.sv =====
// back end: gradient, color selection, blending and output register
module fgrb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fgrb_pkg::cfg_t     cfg_i,
  input  logic               empty_i,
  input  fgrb_pkg::work_t    work_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fgrb_pkg::pix_out_t out_data_o
);
  import fgrb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GRAD  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_BLEND = 3'd4;

  // x / 100 as (x * 5243) >> 19, exact for x up to 25500
  localparam int SUM_W       = 15;
  localparam int RCP_W       = 13;
  localparam int BLEND_RCP   = 5243;
  localparam int BLEND_SHIFT = 19;

  logic [2:0]              state_q, state_d;
  work_t                   item_q;
  logic [PROD_W-1:0]       grad_q;
  logic [SUM_W-1:0]        sum_q [3];
  logic [SUM_W-1:0]        sum_d [3];
  pix_out_t                out_q, res;
  logic                    out_valid_q;
  div_req_t                div_req;
  div_resp_t               div_resp;
  logic [7:0]              frame_t, fill_t;
  logic                    err, need_grad, load_out;
  logic [CFG_W:0]          span_e;
  logic [DIVR_W-1:0]       span_q6, divisor;
  logic [6:0]              alpha, alpha_n;
  logic [7:0]              bg_ch [3];
  logic [7:0]              frame_ch [3];
  logic [7:0]              fill_ch [3];
  logic [7:0]              col_ch [3];
  logic [7:0]              blend_ch [3];
  logic [PROD_W:0]         sat_sum [3];
  logic [SUM_W+RCP_W-1:0]  scaled [3];

  // settings checks and gradient divisor
  always_comb begin
    frame_t = cfg_i.frame_pixel[31:24];
    fill_t  = cfg_i.fill_pixel[31:24];
    err     = (frame_t > PCT_FULL) || (fill_t > PCT_FULL) || (cfg_i.fill_style > STYLE_HREV);
    span_e  = (CFG_W+1)'(cfg_i.gradient_span) + (CFG_W+1)'(cfg_i.gradient_span[CFG_W-1:8])
            + (CFG_W+1)'(1);
    span_q6 = DIVR_W'(span_e[CFG_W:8]);
    divisor = (span_q6 == '0) ? DIVR_W'(1) : span_q6;
    need_grad = !err && !item_q.frame && (cfg_i.fill_style != STYLE_FLAT);
  end

  // per channel color choice and blend
  always_comb begin
    bg_ch[0]    = item_q.bg.bg_blue;
    bg_ch[1]    = item_q.bg.bg_green;
    bg_ch[2]    = item_q.bg.bg_red;
    alpha       = item_q.frame ? 7'(PCT_FULL - frame_t) : 7'(PCT_FULL - fill_t);
    alpha_n     = 7'(PCT_FULL) - alpha;
    for (int i = 0; i < 3; i++) begin
      frame_ch[i] = cfg_i.frame_pixel[8*i +: 8];
      fill_ch[i]  = cfg_i.fill_pixel[8*i +: 8];
      sat_sum[i]  = (PROD_W+1)'(fill_ch[i]) + (PROD_W+1)'(grad_q);
      col_ch[i]   = item_q.frame ? frame_ch[i]
                  : ((sat_sum[i] > (PROD_W+1)'(PIX_MAX)) ? PIX_MAX : sat_sum[i][7:0]);
      sum_d[i]    = SUM_W'(bg_ch[i]) * SUM_W'(alpha_n) + SUM_W'(col_ch[i]) * SUM_W'(alpha);
      scaled[i]   = (SUM_W+RCP_W)'(sum_q[i]) * (SUM_W+RCP_W)'(BLEND_RCP);
      blend_ch[i] = scaled[i][BLEND_SHIFT +: 8];
    end
    res.out_blue      = err ? bg_ch[0] : blend_ch[0];
    res.out_green     = err ? bg_ch[1] : blend_ch[1];
    res.out_red       = err ? bg_ch[2] : blend_ch[2];
    res.last_pixel    = item_q.last;
    res.setting_error = err;
  end

  // gradient divider
  assign div_req.start    = (state_q == ST_GRAD) && need_grad;
  assign div_req.dividend = PROD_W'(cfg_i.gradient_step) * PROD_W'(item_q.pos);
  assign div_req.divisor  = divisor;

  fgrb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign load_out = (state_q == ST_BLEND) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (!empty_i) state_d = ST_GRAD;
      ST_GRAD:  state_d = need_grad ? ST_DIV : ST_SUM;
      ST_DIV:   if (div_resp.done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_BLEND;
      ST_BLEND: if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= work_i;
    end
    if ((state_q == ST_GRAD) && !need_grad) begin
      grad_q <= '0;
    end else if ((state_q == ST_DIV) && div_resp.done) begin
      grad_q <= div_resp.quotient;
    end
    if (state_q == ST_SUM) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_resp.done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

  a_error_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && err) |=> (out_q.out_blue == $past(item_q.bg.bg_blue)) &&
                          (out_q.out_green == $past(item_q.bg.bg_green)) &&
                          (out_q.out_red == $past(item_q.bg.bg_red)))
    else $error("invalid settings did not pass the background through");

endmodule

// ===== src/framed_gradient_rect_blender_top.sv =====
// top level of the framed gradient rectangle blender with its register file
//
// Usage: software clips the rectangle, writes the eight registers through the
// cfg_we_i / cfg_index_i / cfg_wdata_i port while the block is idle, then
// streams the rectangle's background pixels in raster order on the input
// channel (valid/ready). Each input transfer yields one blended pixel on the
// output channel (valid/ready); last_pixel marks the final pixel of the
// rectangle and setting_error flags invalid transparency or fill style.
// An input pixel passes through the queue and then the back end's idle,
// gradient, sum and blend states into the output register; for gradient
// interior pixels the one-bit-per-cycle divider of the gradient term holds the
// back end in its divide state between gradient and sum. The back end handles
// one pixel at a time. A two-entry queue lets the front accept pixels while
// the back works.
// Reset clears the row and column counters, the queue and the output valid
// flag and loads the register reset values (width and height 1, span 255).
// When the receiver stalls, the result holds in the output register, the
// back end waits with the next result, and the queue fills before input
// ready drops.
module framed_gradient_rect_blender_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fgrb_pkg::pix_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fgrb_pkg::pix_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);
  import fgrb_pkg::*;

  cfg_t  cfg_q;
  work_t push_data, pop_data;
  logic  push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_pixel   <= '0;
      cfg_q.fill_pixel    <= '0;
      cfg_q.fill_style    <= STYLE_FLAT;
      cfg_q.gradient_step <= '0;
      cfg_q.rect_width    <= CFG_W'(1);
      cfg_q.rect_height   <= CFG_W'(1);
      cfg_q.frame_width   <= '0;
      cfg_q.gradient_span <= CFG_W'(PIX_MAX);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_PIXEL:   cfg_q.frame_pixel   <= cfg_wdata_i;
        REG_FILL_PIXEL:    cfg_q.fill_pixel    <= cfg_wdata_i;
        REG_FILL_STYLE:    cfg_q.fill_style    <= cfg_wdata_i[2:0];
        REG_GRADIENT_STEP: cfg_q.gradient_step <= cfg_wdata_i[7:0];
        REG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_wdata_i[CFG_W-1:0];
        REG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_wdata_i[CFG_W-1:0];
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata_i[CFG_W-1:0];
        REG_GRADIENT_SPAN: cfg_q.gradient_span <= cfg_wdata_i[CFG_W-1:0];
      endcase
    end
  end

  fgrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .work_o     (push_data)
  );

  fgrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  fgrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .work_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
